>>> sv/shortest_path_relaxation_engine_assert.svh
// Assertion macros shared by the shortest path relaxation engine modules.
// Depends on nothing; each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef SHORTEST_PATH_RELAXATION_ENGINE_ASSERT_SVH
`define SHORTEST_PATH_RELAXATION_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPRE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> sv/spre_pkg.sv
// Package of the shortest path relaxation engine: controller states, register
// indexes and the command and status structs. Depends on nothing.
package spre_pkg;

	localparam logic [0:0] CFG_VERTEX_COUNT  = 1'b0;
	localparam logic [0:0] CFG_SOURCE_VERTEX = 1'b1;

	localparam logic KIND_DISTANCE = 1'b0;
	localparam logic KIND_CYCLE    = 1'b1;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_INIT,
		ST_RELAX_RD,
		ST_RELAX_DV,
		ST_RELAX_WB,
		ST_CHECK_RD,
		ST_CHECK_DV,
		ST_CHECK_EV,
		ST_WALK_RD,
		ST_WALK_EV,
		ST_CYC_HEAD,
		ST_CYC_BODY,
		ST_CYC_TAIL,
		ST_DIST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic init;          // clear vertex state, seed the source
		logic edge_rd;       // read edge store at edge index
		logic vert_rd;       // read tail and head vertex entries
		logic relax_wr;      // commit a relaxation if one applies
		logic edge_clr;      // reset edge index
		logic edge_inc;      // advance edge index
		logic pass_clr;      // reset pass counter
		logic pass_inc;      // advance pass counter
		logic walk_start;    // begin parent walk at the failing head
		logic walk_step;     // push current walk vertex and follow its parent
		logic walk_rd;       // latch the closing vertex of the walk
		logic out_cyc_head;
		logic out_cyc_body;
		logic out_cyc_tail;
		logic out_dist;
		logic load_clr;      // empty edge store after a run
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic edges_empty;
		logic one_vertex;    // only one vertex in use, so there are no relaxation passes
		logic edge_last;     // edge index is at the last stored edge
		logic pass_last;     // current pass is the last relaxation pass
		logic relaxable;     // edge under test can be relaxed
		logic walk_end;      // walk cannot continue
		logic body_done;     // cycle body has reached the closing vertex
		logic dist_last;     // distance output is at the last vertex
	} stat_t;

endpackage

>>> sv/shortest_path_relaxation_engine.sv
// Bellman-Ford engine: edges load one per cycle while busy is low; the edge
// with last_edge set starts a run. A run is vertex_count-1 passes over the stored
// edges (read, vertex read, compare, commit) through the edge memory's single read
// port and the registered relax compare, then a check pass (read, vertex read,
// evaluate), then either vertex_count distance records on consecutive cycles or a
// parent walk of one vertex per cycle followed by the cycle records. Results appear
// for one cycle with strobe high and cannot be stalled. No clearing pass after reset.
`include "shortest_path_relaxation_engine_assert.svh"
module shortest_path_relaxation_engine #(
	parameter int MAX_VERTICES = 32,
	parameter int MAX_EDGES    = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [4:0]         edge_from,
	input  logic [4:0]         edge_to,
	input  logic signed [15:0] edge_weight,
	input  logic               last_edge,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [5:0]         cfg_data,
	output logic               strobe,
	output logic               record_kind,
	output logic [4:0]         vertex_id,
	output logic signed [31:0] path_distance,
	output logic               reachable,
	output logic [4:0]         parent_id,
	output logic               has_parent,
	output logic               last_record
);
	spre_pkg::cmd_t  cmd;
	spre_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	spre_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .last_edge(last_edge),
		.stat(stat), .busy(busy), .cmd(cmd)
	);

	spre_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
		.clk(clk), .arst_n(arst_n), .load_en(start && !busy),
		.edge_from(edge_from), .edge_to(edge_to), .edge_weight(edge_weight),
		.cfg_wr(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .stat(stat), .strobe(strobe), .record_kind(record_kind),
		.vertex_id(vertex_id), .path_distance(path_distance), .reachable(reachable),
		.parent_id(parent_id), .has_parent(has_parent), .last_record(last_record)
	);

	`SPRE_ASSERT_IMP(a_no_strobe_idle_start, clk, arst_n, strobe && last_record,
		!$past(strobe && last_record))
	`SPRE_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy && last_edge, busy)
	`SPRE_ASSERT_IMP(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready)
endmodule

>>> sv/spre_datapath.sv
// Datapath of the shortest path relaxation engine: edge memory, vertex state,
// relaxation adder and compare, parent walk stack and result registers. Uses spre_pkg.
`include "shortest_path_relaxation_engine_assert.svh"
module spre_datapath #(
	parameter int MAX_VERTICES = 32,
	parameter int MAX_EDGES    = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_en,
	input  logic [4:0]          edge_from,
	input  logic [4:0]          edge_to,
	input  logic signed [15:0]  edge_weight,
	input  logic                cfg_wr,
	input  logic [0:0]          cfg_idx,
	input  logic [5:0]          cfg_data,
	input  spre_pkg::cmd_t      cmd,
	output spre_pkg::stat_t     stat,
	output logic                strobe,
	output logic                record_kind,
	output logic [4:0]          vertex_id,
	output logic signed [31:0]  path_distance,
	output logic                reachable,
	output logic [4:0]          parent_id,
	output logic                has_parent,
	output logic                last_record
);
	localparam int EW = $clog2(MAX_EDGES + 1);
	localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int VA = $clog2(MAX_VERTICES);
	localparam int VW = $clog2(MAX_VERTICES + 1);

	logic [4:0]         tail_mem [MAX_EDGES];
	logic [4:0]         head_mem [MAX_EDGES];
	logic signed [15:0] wt_mem   [MAX_EDGES];
	logic signed [31:0] dist_q   [MAX_VERTICES];
	logic [5:0]         pred_q   [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] reach_q, visit_q;
	logic [4:0]         stack_q  [MAX_VERTICES];

	logic [EW-1:0] loaded_q, eidx_q;
	logic [VW-1:0] vc_eff, pass_q, sp_q, oidx_q;
	logic [5:0]    vc_cfg_q;
	logic [4:0]    src_q;
	logic [4:0]    et_q, eh_q;
	logic signed [15:0] ew_q;
	logic          eok_q;
	logic signed [31:0] du_q, dv_q;
	logic          ru_q, rv_q;
	logic signed [33:0] sum_q;
	logic          relax_q;
	logic [5:0]    walk_q, close_q;

	always_comb begin
		if (vc_cfg_q == 6'd0) vc_eff = VW'(1);
		else if ({1'b0, vc_cfg_q} > 7'(MAX_VERTICES)) vc_eff = VW'(MAX_VERTICES);
		else vc_eff = VW'(vc_cfg_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_cfg_q <= 6'd32;
			src_q    <= 5'd0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				spre_pkg::CFG_VERTEX_COUNT:  vc_cfg_q <= cfg_data;
				spre_pkg::CFG_SOURCE_VERTEX: src_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Edge memory: written during loading, read in passes at one address.
	always_ff @(posedge clk) begin
		if (load_en && loaded_q < EW'(MAX_EDGES)) begin
			tail_mem[loaded_q[EA-1:0]] <= edge_from;
			head_mem[loaded_q[EA-1:0]] <= edge_to;
			wt_mem[loaded_q[EA-1:0]]   <= edge_weight;
		end
		if (cmd.edge_rd) begin
			et_q <= tail_mem[eidx_q[EA-1:0]];
			eh_q <= head_mem[eidx_q[EA-1:0]];
			ew_q <= wt_mem[eidx_q[EA-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) loaded_q <= '0;
		else if (cmd.load_clr) loaded_q <= '0;
		else if (load_en && loaded_q < EW'(MAX_EDGES)) loaded_q <= loaded_q + EW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eidx_q <= '0;
			pass_q <= '0;
		end else begin
			if (cmd.edge_clr) eidx_q <= '0;
			else if (cmd.edge_inc) eidx_q <= eidx_q + EW'(1);
			if (cmd.pass_clr) pass_q <= VW'(1);
			else if (cmd.pass_inc) pass_q <= pass_q + VW'(1);
		end
	end

	// Vertex operands of the edge under test.
	always_ff @(posedge clk) begin
		if (cmd.vert_rd) begin
			eok_q <= {1'b0, et_q} < 6'(vc_eff) && {1'b0, eh_q} < 6'(vc_eff);
			du_q  <= dist_q[et_q[VA-1:0]];
			dv_q  <= dist_q[eh_q[VA-1:0]];
			ru_q  <= reach_q[et_q[VA-1:0]];
			rv_q  <= reach_q[eh_q[VA-1:0]];
		end
	end

	logic signed [33:0] sum_c;
	logic               relax_c;
	assign sum_c   = 34'(du_q) + 34'(ew_q);
	assign relax_c = eok_q && ru_q && (!rv_q || sum_c < 34'(dv_q));

	always_ff @(posedge clk) begin
		sum_q   <= sum_c;
		relax_q <= relax_c;
	end

	logic signed [31:0] sat_c;
	always_comb begin
		if (sum_q > 34'sd2147483647) sat_c = 32'sh7fffffff;
		else if (sum_q < -34'sd2147483648) sat_c = 32'sh80000000;
		else sat_c = sum_q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= '0;
			visit_q <= '0;
		end else if (cmd.init) begin
			reach_q <= ({1'b0, src_q} < 6'(vc_eff))
				? (MAX_VERTICES'(1) << src_q[VA-1:0]) : '0;
		end else if (cmd.relax_wr && relax_q) begin
			reach_q[eh_q[VA-1:0]] <= 1'b1;
		end else if (cmd.walk_start) begin
			visit_q <= MAX_VERTICES'(1) << eh_q[VA-1:0];
		end else if (cmd.walk_step) begin
			visit_q[walk_q[VA-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			for (int i = 0; i < MAX_VERTICES; i++) begin
				pred_q[i] <= 6'd63;
				dist_q[i] <= '0;
			end
		end else if (cmd.relax_wr && relax_q) begin
			dist_q[eh_q[VA-1:0]] <= sat_c;
			pred_q[eh_q[VA-1:0]] <= {1'b0, et_q};
		end
	end

	// Parent walk: walk_q is the next candidate vertex.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sp_q <= '0;
		else if (cmd.walk_start) sp_q <= VW'(1);
		else if (cmd.walk_step) sp_q <= sp_q + VW'(1);
		else if (cmd.out_cyc_body) sp_q <= sp_q - VW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			stack_q[0] <= eh_q;
			walk_q     <= pred_q[eh_q[VA-1:0]];
		end else if (cmd.walk_step) begin
			stack_q[sp_q[VA-1:0]] <= walk_q[4:0];
			walk_q <= pred_q[walk_q[VA-1:0]];
		end
		if (cmd.walk_rd) begin
			if (walk_q < 6'(MAX_VERTICES) && visit_q[walk_q[VA-1:0]]) close_q <= walk_q;
			else close_q <= {1'b0, stack_q[sp_q[VA-1:0] - VA'(1)]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) oidx_q <= '0;
		else if (cmd.init) oidx_q <= '0;
		else if (cmd.out_dist) oidx_q <= oidx_q + VW'(1);
	end

	logic walk_end_c;
	assign walk_end_c = !(walk_q < 6'(MAX_VERTICES)) || visit_q[walk_q[VA-1:0]]
		|| !(sp_q < VW'(MAX_VERTICES));

	always_comb begin
		stat.edges_empty = loaded_q == '0;
		stat.one_vertex  = vc_eff == VW'(1);
		stat.edge_last   = eidx_q + EW'(1) >= loaded_q;
		stat.pass_last   = pass_q + VW'(1) >= vc_eff;
		stat.relaxable   = relax_c;
		stat.walk_end    = walk_end_c;
		stat.body_done   = sp_q == '0 || {1'b0, stack_q[sp_q[VA-1:0] - VA'(1)]} == close_q;
		stat.dist_last   = oidx_q + VW'(1) == vc_eff;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else strobe <= cmd.out_cyc_head | cmd.out_cyc_body | cmd.out_cyc_tail | cmd.out_dist;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_dist) begin
			record_kind   <= spre_pkg::KIND_DISTANCE;
			vertex_id     <= 5'(oidx_q);
			reachable     <= reach_q[oidx_q[VA-1:0]];
			path_distance <= reach_q[oidx_q[VA-1:0]] ? dist_q[oidx_q[VA-1:0]] : '0;
			has_parent    <= pred_q[oidx_q[VA-1:0]] < 6'(MAX_VERTICES);
			parent_id     <= (pred_q[oidx_q[VA-1:0]] < 6'(MAX_VERTICES))
				? pred_q[oidx_q[VA-1:0]][4:0] : 5'd0;
			last_record   <= oidx_q + VW'(1) == vc_eff;
		end else begin
			record_kind   <= spre_pkg::KIND_CYCLE;
			vertex_id     <= cmd.out_cyc_body ? stack_q[sp_q[VA-1:0] - VA'(1)] : close_q[4:0];
			reachable     <= 1'b0;
			path_distance <= '0;
			has_parent    <= 1'b0;
			parent_id     <= '0;
			last_record   <= cmd.out_cyc_tail;
		end
	end

	`SPRE_ASSERT_IMP(a_load_bound, clk, arst_n, 1'b1, loaded_q <= EW'(MAX_EDGES))
	`SPRE_ASSERT_NEXT(a_last_strobe, clk, arst_n, cmd.out_cyc_tail, strobe && last_record)
	`SPRE_ASSERT_IMP(a_stack_bound, clk, arst_n, 1'b1, sp_q <= VW'(MAX_VERTICES))
endmodule

>>> sv/spre_ctrl.sv
// Controller of the shortest path relaxation engine: sequences loading,
// relaxation passes, check pass, cycle walk and output. Uses spre_pkg.
`include "shortest_path_relaxation_engine_assert.svh"
module spre_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            last_edge,
	input  spre_pkg::stat_t stat,
	output logic            busy,
	output spre_pkg::cmd_t  cmd
);
	spre_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= spre_pkg::ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			spre_pkg::ST_LOAD: begin
				busy = 1'b0;
				if (start && last_edge) state_d = spre_pkg::ST_INIT;
			end
			spre_pkg::ST_INIT: begin
				cmd.init     = 1'b1;
				cmd.edge_clr = 1'b1;
				cmd.pass_clr = 1'b1;
				if (stat.edges_empty) state_d = spre_pkg::ST_DIST_OUT;
				else if (stat.one_vertex) state_d = spre_pkg::ST_CHECK_RD;
				else state_d = spre_pkg::ST_RELAX_RD;
			end
			spre_pkg::ST_RELAX_RD: begin
				cmd.edge_rd = 1'b1;
				state_d = spre_pkg::ST_RELAX_DV;
			end
			spre_pkg::ST_RELAX_DV: begin
				cmd.vert_rd = 1'b1;
				state_d = spre_pkg::ST_RELAX_WB;
			end
			spre_pkg::ST_RELAX_WB: begin
				// The compare is registered at the end of this cycle; the commit follows.
				state_d = spre_pkg::ST_CHECK_EV;
			end
			spre_pkg::ST_CHECK_EV: begin
				cmd.relax_wr = 1'b1;
				if (stat.edge_last) begin
					cmd.edge_clr = 1'b1;
					if (stat.pass_last) state_d = spre_pkg::ST_CHECK_RD;
					else begin
						cmd.pass_inc = 1'b1;
						state_d = spre_pkg::ST_RELAX_RD;
					end
				end else begin
					cmd.edge_inc = 1'b1;
					state_d = spre_pkg::ST_RELAX_RD;
				end
			end
			spre_pkg::ST_CHECK_RD: begin
				cmd.edge_rd = 1'b1;
				state_d = spre_pkg::ST_CHECK_DV;
			end
			spre_pkg::ST_CHECK_DV: begin
				cmd.vert_rd = 1'b1;
				state_d = spre_pkg::ST_WALK_RD;
			end
			spre_pkg::ST_WALK_RD: begin
				// Check pass evaluation of the edge under test.
				if (stat.relaxable) begin
					cmd.walk_start = 1'b1;
					state_d = spre_pkg::ST_WALK_EV;
				end else if (stat.edge_last) begin
					state_d = spre_pkg::ST_DIST_OUT;
				end else begin
					cmd.edge_inc = 1'b1;
					state_d = spre_pkg::ST_CHECK_RD;
				end
			end
			spre_pkg::ST_WALK_EV: begin
				if (stat.walk_end) begin
					cmd.walk_rd = 1'b1;
					state_d = spre_pkg::ST_CYC_HEAD;
				end else cmd.walk_step = 1'b1;
			end
			spre_pkg::ST_CYC_HEAD: begin
				cmd.out_cyc_head = 1'b1;
				state_d = spre_pkg::ST_CYC_BODY;
			end
			spre_pkg::ST_CYC_BODY: begin
				if (stat.body_done) state_d = spre_pkg::ST_CYC_TAIL;
				else cmd.out_cyc_body = 1'b1;
			end
			spre_pkg::ST_CYC_TAIL: begin
				cmd.out_cyc_tail = 1'b1;
				cmd.load_clr = 1'b1;
				state_d = spre_pkg::ST_LOAD;
			end
			spre_pkg::ST_DIST_OUT: begin
				cmd.out_dist = 1'b1;
				if (stat.dist_last) begin
					cmd.load_clr = 1'b1;
					state_d = spre_pkg::ST_LOAD;
				end
			end
			default: state_d = spre_pkg::ST_LOAD;
		endcase
	end

	`SPRE_ASSERT_NEXT(a_run_starts, clk, arst_n, !busy && start && last_edge,
		state_q == spre_pkg::ST_INIT)
	`SPRE_ASSERT_IMP(a_one_output, clk, arst_n, 1'b1,
		$onehot0({cmd.out_cyc_head, cmd.out_cyc_body, cmd.out_cyc_tail, cmd.out_dist}))
	`SPRE_ASSERT_IMP(a_idle_quiet, clk, arst_n, !busy, cmd == '0)
endmodule

>>> dv/testbench.sv
// Testbench for shortest_path_relaxation_engine: graphs go in edge by edge, and a
// Bellman-Ford predictor checks every distance and negative-cycle record.
// Depends on spre_pkg and the engine RTL.
`timescale 1ns / 1ps
module testbench;

	localparam int NV = 32;
	localparam int NE = 256;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic               kind;
		logic [4:0]         vid;
		logic signed [31:0] pdist;
		logic               reach;
		logic [4:0]         par;
		logic               hasp;
		logic               last;
	} path_rec_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [4:0] edge_from = 0;
	logic [4:0] edge_to = 0;
	logic signed [15:0] edge_weight = 0;
	logic last_edge = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [0:0] cfg_index = 0;
	logic [5:0] cfg_data = 0;
	logic strobe;
	logic record_kind;
	logic [4:0] vertex_id;
	logic signed [31:0] path_distance;
	logic reachable;
	logic [4:0] parent_id;
	logic has_parent;
	logic last_record;

	shortest_path_relaxation_engine u_top (.*);

	// Predictor state.
	logic [4:0] tails [NE];
	logic [4:0] heads [NE];
	logic signed [15:0] weights [NE];
	int n_loaded = 0;
	logic signed [31:0] dist_of [NV];
	bit reached [NV];
	logic [5:0] pred_of [NV];
	logic [5:0] vc_reg = 6'd32;
	logic [4:0] src_reg = 5'd0;

	path_rec_t expected_records [$];
	int errors = 0;
	int cycles = 0;
	bit idle_on = 1;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic bit edge_relaxable(int e, int vc, output longint sum);
		int u;
		int v;
		u = tails[e];
		v = heads[e];
		sum = 0;
		if (u >= vc || v >= vc || !reached[u])
			return 0;
		sum = longint'(dist_of[u]) + longint'(weights[e]);
		return !reached[v] || sum < longint'(dist_of[v]);
	endfunction

	function automatic path_rec_t mk_rec(logic kind, int vid, logic signed [31:0] d, bit r,
			int par, bit hp, bit last);
		path_rec_t rec;
		rec.kind = kind;
		rec.vid = vid[4:0];
		rec.pdist = d;
		rec.reach = r;
		rec.par = par[4:0];
		rec.hasp = hp;
		rec.last = last;
		return rec;
	endfunction

	task automatic predict_cycle(int first);
		bit seen [NV];
		int chain [NV];
		int sp;
		int t;
		int closing;
		int i;
		foreach (seen[k]) seen[k] = 0;
		sp = 0;
		seen[first] = 1;
		chain[sp++] = first;
		t = pred_of[first];
		while (t < NV && !seen[t] && sp < NV) begin
			chain[sp++] = t;
			seen[t] = 1;
			t = pred_of[t];
		end
		closing = (t < NV && seen[t]) ? t : chain[sp - 1];
		expected_records.push_back(mk_rec(spre_pkg::KIND_CYCLE, closing, 0, 0, 0, 0, 0));
		i = sp;
		while (i > 0 && chain[i - 1] != closing) begin
			expected_records.push_back(mk_rec(spre_pkg::KIND_CYCLE, chain[i - 1], 0, 0, 0, 0,
				0));
			i--;
		end
		expected_records.push_back(mk_rec(spre_pkg::KIND_CYCLE, closing, 0, 0, 0, 0, 1));
	endtask

	task automatic relax_graph();
		int vc;
		longint s;
		bit hp;
		vc = vc_reg;
		if (vc < 1) vc = 1;
		if (vc > NV) vc = NV;
		for (int i = 0; i < NV; i++) begin
			reached[i] = 0;
			pred_of[i] = 6'd63;
			dist_of[i] = 0;
		end
		if (src_reg < vc) reached[src_reg] = 1;
		for (int p = 1; p < vc; p++)
			for (int e = 0; e < n_loaded; e++)
				if (edge_relaxable(e, vc, s)) begin
					// Store saturated, compare on the exact sum.
					dist_of[heads[e]] = s > 64'sd2147483647 ? 32'sh7fffffff :
						s < -64'sd2147483648 ? 32'sh80000000 : s[31:0];
					pred_of[heads[e]] = tails[e];
					reached[heads[e]] = 1;
				end
		for (int e = 0; e < n_loaded; e++)
			if (edge_relaxable(e, vc, s)) begin
				predict_cycle(heads[e]);
				return;
			end
		for (int i = 0; i < vc; i++) begin
			hp = pred_of[i] < NV;
			expected_records.push_back(mk_rec(spre_pkg::KIND_DISTANCE, i,
				reached[i] ? dist_of[i] : 0, reached[i], hp ? pred_of[i] : 0, hp, i + 1 == vc));
		end
	endtask

	// Results cannot be stalled, so every strobe is checked on the edge that ends it.
	always @(posedge clk) begin
		path_rec_t want;
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
			if (strobe) begin
				if (expected_records.size() == 0) begin
					report($sformatf("unexpected record for vertex %0d", vertex_id));
				end else begin
					want = expected_records.pop_front();
					if (record_kind !== want.kind)
						report($sformatf("record_kind %0b, want %0b", record_kind, want.kind));
					if (vertex_id !== want.vid)
						report($sformatf("vertex_id %0d, want %0d", vertex_id, want.vid));
					if (path_distance !== want.pdist)
						report($sformatf("path_distance %0d, want %0d", path_distance,
							want.pdist));
					if (reachable !== want.reach)
						report($sformatf("reachable %0b, want %0b", reachable, want.reach));
					if (parent_id !== want.par)
						report($sformatf("parent_id %0d, want %0d", parent_id, want.par));
					if (has_parent !== want.hasp)
						report($sformatf("has_parent %0b, want %0b", has_parent, want.hasp));
					if (last_record !== want.last)
						report($sformatf("last_record %0b, want %0b", last_record, want.last));
				end
			end
		end
	end

	// Called at a falling edge; returns at a falling edge with start still high.
	task automatic send_edge(int from, int to, int w, bit last);
		if (idle_on && $urandom_range(99) < 28) begin
			start = 0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		start = 1;
		edge_from = from[4:0];
		edge_to = to[4:0];
		edge_weight = w[15:0];
		last_edge = last;
		do @(posedge clk); while (busy);
		if (n_loaded < NE) begin
			tails[n_loaded] = from[4:0];
			heads[n_loaded] = to[4:0];
			weights[n_loaded] = w[15:0];
			n_loaded++;
		end
		if (last) begin
			relax_graph();
			n_loaded = 0;
		end
		@(negedge clk);
	endtask

	task automatic settle();
		start = 0;
		while (expected_records.size() > 0) @(negedge clk);
		repeat (20) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, int value);
		settle();
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = value[5:0];
		do @(posedge clk); while (!cfg_ready);
		if (idx == spre_pkg::CFG_VERTEX_COUNT) vc_reg = value[5:0];
		else src_reg = value[4:0];
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic random_graph(int vc, int n_edges, bit allow_negative);
		int w;
		for (int i = 0; i < n_edges; i++) begin
			w = allow_negative ? $urandom_range(0, 40) - 8 : $urandom_range(0, 50);
			if ($urandom_range(9) == 0) w = int'($urandom_range(0, 65535)) - 32768;
			// A few endpoints fall outside the vertex range to exercise skipping.
			send_edge($urandom_range(9) == 0 ? $urandom_range(31) : $urandom_range(vc - 1),
				$urandom_range(9) == 0 ? $urandom_range(31) : $urandom_range(vc - 1),
				w, i == n_edges - 1);
		end
	endtask

	task automatic test_shortest_paths();
		write_reg(spre_pkg::CFG_VERTEX_COUNT, 5);
		write_reg(spre_pkg::CFG_SOURCE_VERTEX, 0);
		send_edge(0, 1, 4, 0);
		send_edge(0, 2, 1, 0);
		send_edge(2, 1, -2, 0);
		send_edge(1, 3, 3, 0);
		send_edge(3, 9, 1, 0);
		send_edge(4, 0, 1, 1);
		settle();
	endtask

	task automatic test_negative_cycle();
		write_reg(spre_pkg::CFG_VERTEX_COUNT, 4);
		send_edge(0, 1, 1, 0);
		send_edge(1, 2, 2, 0);
		send_edge(2, 3, -1, 0);
		send_edge(3, 1, -3, 1);
		// Cycle back through the source itself.
		send_edge(0, 1, -5, 0);
		send_edge(1, 0, 2, 1);
		settle();
	endtask

	task automatic test_extremes();
		write_reg(spre_pkg::CFG_VERTEX_COUNT, 3);
		send_edge(0, 1, 32767, 0);
		send_edge(1, 2, 32767, 0);
		send_edge(0, 2, -32768, 1);
		write_reg(spre_pkg::CFG_SOURCE_VERTEX, 31);
		send_edge(31, 0, 5, 1);
		write_reg(spre_pkg::CFG_VERTEX_COUNT, 0);
		write_reg(spre_pkg::CFG_SOURCE_VERTEX, 0);
		send_edge(0, 0, -1, 1);
		write_reg(spre_pkg::CFG_VERTEX_COUNT, 63);
		send_edge(0, 31, -32768, 0);
		send_edge(31, 30, 32767, 1);
		write_reg(spre_pkg::CFG_VERTEX_COUNT, 1);
		send_edge(31, 31, 1, 1);
		settle();
	endtask

	task automatic test_store_full();
		write_reg(spre_pkg::CFG_VERTEX_COUNT, 2);
		for (int i = 0; i < NE + 2; i++)
			send_edge($urandom_range(1), $urandom_range(1), i == NE + 1 ? -100 : 3,
				i == NE + 1);
		settle();
	endtask

	task automatic test_random_graphs();
		int vc;
		for (int g = 0; g < 22; g++) begin
			idle_on = !(g >= 8 && g < 14);
			vc = $urandom_range(2, 8);
			if (g % 7 == 6) vc = 32;
			write_reg(spre_pkg::CFG_VERTEX_COUNT, vc);
			write_reg(spre_pkg::CFG_SOURCE_VERTEX, $urandom_range(9) == 0 ? $urandom_range(31) :
				$urandom_range(vc - 1));
			random_graph(vc, $urandom_range(1, 10), $urandom_range(1));
		end
		idle_on = 1;
		settle();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_shortest_paths();
		test_negative_cycle();
		test_extremes();
		test_store_full();
		test_random_graphs();
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_records.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/spre_pkg.sv
sv/spre_datapath.sv
sv/spre_ctrl.sv
sv/shortest_path_relaxation_engine.sv
dv/testbench.sv
